// ===== hw/rtl/trnh_pkg.sv =====
// ----------------------------------------------------------------------------
// trnh_pkg
// Shared types and constants for the spanning-tree next-hop lookup.
// ----------------------------------------------------------------------------
package trnh_pkg;

  localparam int NODES_DEFAULT = 16;
  localparam int NODE_FIELD_W  = 4;

  typedef logic [NODE_FIELD_W-1:0] node_field_t;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_RD_A,
    ST_WR_WR_A,
    ST_WR_RD_B,
    ST_WR_WR_B,
    ST_Q_FETCH,
    ST_Q_SCAN,
    ST_Q_BACK,
    ST_Q_DONE
  } state_t;

endpackage

// ===== hw/rtl/trnh_if.sv =====
// ----------------------------------------------------------------------------
// hop_req_if / hop_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface hop_req_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  trnh_pkg::node_field_t node_a;
  trnh_pkg::node_field_t node_b;
  logic                 edge_present;

  modport source (output valid, kind, node_a, node_b, edge_present, input ready);
  modport sink   (input valid, kind, node_a, node_b, edge_present, output ready);
endinterface

interface hop_rsp_if;
  logic                 valid;
  logic                 ready;
  trnh_pkg::node_field_t next_hop;
  logic                 found;

  modport source (output valid, next_hop, found, input ready);
  modport sink   (input valid, next_hop, found, output ready);
endinterface

// ===== hw/rtl/tree_route_next_hop_top.sv =====
// ----------------------------------------------------------------------------
// tree_route_next_hop_top
// Adjacency store of a spanning tree with a depth-first next-hop lookup.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                   | items
//  req     | in  | kind, node_a, node_b, edge_present       | edge write or query
//  rsp     | out | next_hop, found                          | one per query
//
//  An edge write, once accepted, is a read-modify-write of two rows.
//  A query walks the tree: a descent is a row read then a scan, a retire and
//  step back adds a scan of the on-path neighbours; the walk is serialised by
//  the single row-memory read port and the one priority scanner.
//  Synchronous reset clears every row-valid bit; no clearing pass is needed.
//  req.ready is high only while idle; a stalled rsp holds its item and the
//  block still takes the next request meanwhile.
// ----------------------------------------------------------------------------
module tree_route_next_hop_top #(
  parameter int NODES = trnh_pkg::NODES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  hop_req_if.sink      req,
  hop_rsp_if.source    rsp
);

  localparam int IDX_W  = $clog2(NODES);
  localparam int LIMIT  = 2 * NODES + 2;
  localparam int STEP_W = $clog2(LIMIT + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [NODES-1:0] row_t;

  trnh_pkg::state_t state, state_next;

  // row memory
  row_t              mem [NODES];
  logic [NODES-1:0]  row_vld;
  logic              mem_we;
  idx_t              mem_waddr;
  row_t              mem_wdata;
  idx_t              mem_raddr;
  row_t              rd_row;
  logic              rd_vld;
  row_t              row;

  // item and walk registers
  idx_t              op_a, op_a_next;
  idx_t              op_b, op_b_next;
  logic              present, present_next;
  idx_t              cur, cur_next;
  logic [STEP_W-1:0] steps, steps_next;
  row_t              onpath, onpath_next;
  row_t              retired, retired_next;
  idx_t              res_hop, res_hop_next;
  logic              res_found, res_found_next;

  // output register
  logic              out_valid, out_valid_next;
  idx_t              out_hop, out_hop_next;
  logic              out_found, out_found_next;

  // scanner
  row_t              scan_vec;
  row_t              tgt_vec;
  row_t              row_mod;
  idx_t              first_idx;
  logic              first_any;
  logic              a_in, b_in;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld[mem_waddr] <= 1'b1;
      end
      rd_vld <= row_vld[mem_raddr];
    end
  end

  assign row = rd_vld ? rd_row : '0;

  assign a_in = 32'(req.node_a) < NODES;
  assign b_in = 32'(req.node_b) < NODES;

  always_comb begin
    tgt_vec       = '0;
    tgt_vec[op_b] = 1'b1;
  end

  // lowest set bit of the scan vector
  always_comb begin
    first_idx = '0;
    first_any = 1'b0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (scan_vec[i]) begin
        first_idx = idx_t'(i);
        first_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trnh_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_a      <= op_a_next;
    op_b      <= op_b_next;
    present   <= present_next;
    cur       <= cur_next;
    steps     <= steps_next;
    onpath    <= onpath_next;
    retired   <= retired_next;
    res_hop   <= res_hop_next;
    res_found <= res_found_next;
    out_hop   <= out_hop_next;
    out_found <= out_found_next;
  end

  always_comb begin
    state_next     = state;
    op_a_next      = op_a;
    op_b_next      = op_b;
    present_next   = present;
    cur_next       = cur;
    steps_next     = steps;
    onpath_next    = onpath;
    retired_next   = retired;
    res_hop_next   = res_hop;
    res_found_next = res_found;
    out_valid_next = out_valid;
    out_hop_next   = out_hop;
    out_found_next = out_found;
    mem_we         = 1'b0;
    mem_waddr      = op_a;
    mem_wdata      = row;
    mem_raddr      = cur;
    scan_vec       = '0;
    row_mod        = row;
    req.ready      = 1'b0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      trnh_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_a_next    = idx_t'(req.node_a);
          op_b_next    = idx_t'(req.node_b);
          present_next = req.edge_present;
          cur_next     = idx_t'(req.node_a);
          steps_next   = '0;
          onpath_next  = '0;
          retired_next = '0;
          if (req.kind == trnh_pkg::KIND_WRITE) begin
            if (a_in && b_in) begin
              state_next = trnh_pkg::ST_WR_RD_A;
            end
          end else if (!(a_in && b_in)) begin
            res_hop_next   = '0;
            res_found_next = 1'b0;
            state_next     = trnh_pkg::ST_Q_DONE;
          end else if (req.node_a == req.node_b) begin
            res_hop_next   = idx_t'(req.node_a);
            res_found_next = 1'b1;
            state_next     = trnh_pkg::ST_Q_DONE;
          end else begin
            state_next = trnh_pkg::ST_Q_FETCH;
          end
        end
      end

      trnh_pkg::ST_WR_RD_A: begin
        mem_raddr  = op_a;
        state_next = trnh_pkg::ST_WR_WR_A;
      end

      trnh_pkg::ST_WR_WR_A: begin
        row_mod[op_b] = present;
        mem_we        = 1'b1;
        mem_waddr     = op_a;
        mem_wdata     = row_mod;
        state_next    = trnh_pkg::ST_WR_RD_B;
      end

      trnh_pkg::ST_WR_RD_B: begin
        mem_raddr  = op_b;
        state_next = trnh_pkg::ST_WR_WR_B;
      end

      trnh_pkg::ST_WR_WR_B: begin
        row_mod[op_a] = present;
        mem_we        = 1'b1;
        mem_waddr     = op_b;
        mem_wdata     = row_mod;
        state_next    = trnh_pkg::ST_IDLE;
      end

      trnh_pkg::ST_Q_FETCH: begin
        if (32'(steps) == LIMIT) begin
          res_hop_next   = '0;
          res_found_next = 1'b0;
          state_next     = trnh_pkg::ST_Q_DONE;
        end else begin
          onpath_next[cur] = 1'b1;
          mem_raddr        = cur;
          state_next       = trnh_pkg::ST_Q_SCAN;
        end
      end

      trnh_pkg::ST_Q_SCAN: begin
        // target or first unvisited neighbour, whichever has the lower index
        scan_vec = row & (tgt_vec | ~(onpath | retired));
        if (first_any) begin
          if (first_idx == op_b) begin
            res_hop_next   = cur;
            res_found_next = 1'b1;
            state_next     = trnh_pkg::ST_Q_DONE;
          end else begin
            cur_next   = first_idx;
            steps_next = steps + 1'b1;
            state_next = trnh_pkg::ST_Q_FETCH;
          end
        end else begin
          onpath_next[cur]  = 1'b0;
          retired_next[cur] = 1'b1;
          state_next        = trnh_pkg::ST_Q_BACK;
        end
      end

      trnh_pkg::ST_Q_BACK: begin
        scan_vec = row & onpath;
        if (first_any) begin
          cur_next   = first_idx;
          steps_next = steps + 1'b1;
          state_next = trnh_pkg::ST_Q_FETCH;
        end else begin
          res_hop_next   = '0;
          res_found_next = 1'b0;
          state_next     = trnh_pkg::ST_Q_DONE;
        end
      end

      trnh_pkg::ST_Q_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_hop_next   = res_hop;
          out_found_next = res_found;
          state_next     = trnh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = trnh_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp.valid    = out_valid;
  assign rsp.next_hop = trnh_pkg::NODE_FIELD_W'(out_hop);
  assign rsp.found    = out_found;

endmodule

// ===== hw/rtl/trnh_checker.sv =====
// ----------------------------------------------------------------------------
// trnh_checker
// Port-level checks on the next-hop lookup, bound to the top level.
// ----------------------------------------------------------------------------
module trnh_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  req_kind,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input trnh_pkg::node_field_t rsp_next_hop,
  input logic                  rsp_found
);

  // every accepted item keeps the block busy in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req.ready high right after an accepted item");

  // an edge write never produces a result item
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_kind == trnh_pkg::KIND_WRITE) |=> !$rose(rsp_valid))
    else $error("result item raised after an edge write");

  // a miss always reports node zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_found) |-> rsp_next_hop == '0)
    else $error("not-found result with non-zero next_hop");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_next_hop) && $stable(rsp_found)))
    else $error("stalled result item changed");

endmodule

bind tree_route_next_hop_top trnh_checker u_trnh_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_kind     (req.kind),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_next_hop (rsp.next_hop),
  .rsp_found    (rsp.found)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the spanning-tree next-hop lookup. Edge writes and next-hop queries
// are sent over the request channel. A local copy of the adjacency matrix
// and a depth-first walk predict each answer. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NODES        = trnh_pkg::NODES_DEFAULT;
  localparam int WALK_LIMIT   = 2 * NODES + 2;
  localparam int DRAIN_CYCLES = 6 * NODES;
  localparam int HOLDOFF_LEN  = 300;
  localparam int RANDOM_ITEMS = 1500;

  typedef enum logic [1:0] {
    MARK_UNVISITED,
    MARK_ON_PATH,
    MARK_RETIRED
  } mark_t;

  typedef struct {
    trnh_pkg::node_field_t start;
    trnh_pkg::node_field_t target;
    trnh_pkg::node_field_t next_hop;
    logic                  found;
  } hop_answer_t;

  logic clk = 1'b0;
  logic rst;

  hop_req_if req_if ();
  hop_rsp_if rsp_if ();

  tree_route_next_hop_top #(.NODES(NODES)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #2 clk = ~clk;

  // local copy of the adjacency matrix
  bit [NODES-1:0] adj_rows [NODES];
  hop_answer_t    pending_hops [$];

  trnh_pkg::node_field_t tree_nodes [NODES];
  int                    tree_size;

  bit sender_idle_en = 1'b1;
  bit rsp_idle_en    = 1'b1;
  bit holdoff_req    = 1'b0;
  int holdoff_cnt    = 0;

  int mismatches = 0;
  int sent_items = 0;
  int n_writes   = 0;
  int n_queries  = 0;
  int n_found    = 0;
  int n_lost     = 0;

  function automatic hop_answer_t predict_next_hop(trnh_pkg::node_field_t start,
                                                   trnh_pkg::node_field_t target);
    mark_t       mark [NODES];
    hop_answer_t ans;
    int          cur;
    int          step;
    int          k;
    bit          moved;
    ans.start    = start;
    ans.target   = target;
    ans.next_hop = '0;
    ans.found    = 1'b0;
    if (start == target) begin
      ans.next_hop = start;
      ans.found    = 1'b1;
      return ans;
    end
    foreach (mark[i]) mark[i] = MARK_UNVISITED;
    cur = start;
    for (step = 0; step < WALK_LIMIT; step++) begin
      moved     = 1'b0;
      mark[cur] = MARK_ON_PATH;
      for (k = 0; k < NODES; k++) begin
        if (adj_rows[cur][k]) begin
          if (k == target) begin
            ans.next_hop = trnh_pkg::node_field_t'(cur);
            ans.found    = 1'b1;
            return ans;
          end
          if (mark[k] == MARK_UNVISITED) begin
            cur   = k;
            moved = 1'b1;
            break;
          end
        end
      end
      if (!moved) begin
        // dead end: retire and step back to the lowest neighbour on the path
        mark[cur] = MARK_RETIRED;
        for (k = 0; k < NODES; k++) begin
          if (adj_rows[cur][k] && mark[k] == MARK_ON_PATH) begin
            cur   = k;
            moved = 1'b1;
            break;
          end
        end
        if (!moved) return ans;
      end
    end
    return ans;
  endfunction

  task automatic send_item(input logic kind, input trnh_pkg::node_field_t a,
                           input trnh_pkg::node_field_t b, input logic present);
    hop_answer_t ans;
    if (sender_idle_en && $urandom_range(0, 99) < 7) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.node_a       <= a;
    req_if.node_b       <= b;
    req_if.edge_present <= present;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sent_items++;
    if (kind == trnh_pkg::KIND_WRITE) begin
      adj_rows[a][b] = present;
      adj_rows[b][a] = present;
      n_writes++;
    end else begin
      ans = predict_next_hop(a, b);
      pending_hops.push_back(ans);
      n_queries++;
      if (ans.found) n_found++;
      else n_lost++;
    end
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic clear_graph();
    int a;
    int b;
    for (a = 0; a < NODES; a++) begin
      for (b = a; b < NODES; b++) begin
        if (adj_rows[a][b])
          send_item(trnh_pkg::KIND_WRITE, trnh_pkg::node_field_t'(a),
                    trnh_pkg::node_field_t'(b), 1'b0);
      end
    end
  endtask

  // random tree over a shuffled subset of n nodes
  task automatic build_tree(input int n);
    int                    i;
    int                    j;
    trnh_pkg::node_field_t t;
    for (i = 0; i < NODES; i++) tree_nodes[i] = trnh_pkg::node_field_t'(i);
    for (i = NODES - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      t             = tree_nodes[i];
      tree_nodes[i] = tree_nodes[j];
      tree_nodes[j] = t;
    end
    tree_size = n;
    for (i = 1; i < n; i++) begin
      j = $urandom_range(0, i - 1);
      if ($urandom_range(0, 1))
        send_item(trnh_pkg::KIND_WRITE, tree_nodes[i], tree_nodes[j], 1'b1);
      else
        send_item(trnh_pkg::KIND_WRITE, tree_nodes[j], tree_nodes[i], 1'b1);
    end
  endtask

  task automatic send_tree_query();
    trnh_pkg::node_field_t a;
    trnh_pkg::node_field_t b;
    int                    r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      a = tree_nodes[$urandom_range(0, tree_size - 1)];
      b = tree_nodes[$urandom_range(0, tree_size - 1)];
    end else if (r < 80) begin
      a = trnh_pkg::node_field_t'($urandom_range(0, NODES - 1));
      b = a;
    end else begin
      a = trnh_pkg::node_field_t'($urandom_range(0, NODES - 1));
      b = trnh_pkg::node_field_t'($urandom_range(0, NODES - 1));
    end
    send_item(trnh_pkg::KIND_QUERY, a, b, logic'($urandom_range(0, 1)));
  endtask

  task automatic test_directed();
    send_item(trnh_pkg::KIND_QUERY, 4'd0, 4'd15, 1'b0);  // empty matrix
    send_item(trnh_pkg::KIND_QUERY, 4'd0, 4'd0, 1'b1);
    send_item(trnh_pkg::KIND_QUERY, 4'd15, 4'd15, 1'b0);
    send_item(trnh_pkg::KIND_WRITE, 4'd0, 4'd15, 1'b1);
    send_item(trnh_pkg::KIND_QUERY, 4'd0, 4'd15, 1'b1);
    send_item(trnh_pkg::KIND_QUERY, 4'd15, 4'd0, 1'b0);
    send_item(trnh_pkg::KIND_WRITE, 4'd5, 4'd5, 1'b1);   // self edge
    send_item(trnh_pkg::KIND_QUERY, 4'd5, 4'd3, 1'b0);
    send_item(trnh_pkg::KIND_WRITE, 4'd0, 4'd1, 1'b1);
    send_item(trnh_pkg::KIND_WRITE, 4'd1, 4'd2, 1'b1);
    send_item(trnh_pkg::KIND_WRITE, 4'd2, 4'd3, 1'b1);
    send_item(trnh_pkg::KIND_QUERY, 4'd0, 4'd15, 1'b0);  // descends 1-2-3 first, backtracks
    send_item(trnh_pkg::KIND_QUERY, 4'd3, 4'd15, 1'b0);
    send_item(trnh_pkg::KIND_QUERY, 4'd15, 4'd3, 1'b1);
    send_item(trnh_pkg::KIND_WRITE, 4'd0, 4'd15, 1'b0);
    send_item(trnh_pkg::KIND_QUERY, 4'd0, 4'd15, 1'b0);
    send_item(trnh_pkg::KIND_WRITE, 4'd10, 4'd12, 1'b1);
    send_item(trnh_pkg::KIND_WRITE, 4'd12, 4'd10, 1'b0); // cleared from the other end
    send_item(trnh_pkg::KIND_QUERY, 4'd10, 4'd12, 1'b0);
    send_item(trnh_pkg::KIND_WRITE, 4'd3, 4'd0, 1'b1);   // closes a cycle
    send_item(trnh_pkg::KIND_QUERY, 4'd1, 4'd9, 1'b0);
    send_item(trnh_pkg::KIND_QUERY, 4'd2, 4'd0, 1'b1);
    clear_graph();
    wait_drain();
  endtask

  task automatic test_random_trees();
    int n;
    int q;
    while (sent_items < RANDOM_ITEMS) begin
      clear_graph();
      n = ($urandom_range(0, 1)) ? $urandom_range(2, 6) : $urandom_range(7, NODES);
      build_tree(n);
      // noise: extra or removed edges, may leave cycles or split the tree
      if ($urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(1, 3))
          send_item(trnh_pkg::KIND_WRITE,
                    trnh_pkg::node_field_t'($urandom_range(0, NODES - 1)),
                    trnh_pkg::node_field_t'($urandom_range(0, NODES - 1)),
                    logic'($urandom_range(0, 1)));
      end
      q = $urandom_range(8, 16);
      repeat (q) send_tree_query();
    end
    wait_drain();
  endtask

  task automatic test_output_holdoff();
    clear_graph();
    build_tree(NODES);
    holdoff_req = 1'b1;
    repeat (24) send_tree_query();
    wait_drain();
  endtask

  task automatic test_no_idle();
    sender_idle_en = 1'b0;
    rsp_idle_en    = 1'b0;
    repeat (4) begin
      clear_graph();
      build_tree($urandom_range(2, NODES));
      repeat (30) send_tree_query();
    end
    wait_drain();
    sender_idle_en = 1'b1;
    rsp_idle_en    = 1'b1;
  endtask

  // result channel ready, with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_cnt <= HOLDOFF_LEN;
      rsp_if.ready <= 1'b0;
    end else if (holdoff_cnt > 0) begin
      holdoff_cnt <= holdoff_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else if (rsp_idle_en && $urandom_range(0, 99) < 7) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : hop_check
    hop_answer_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_hops.size() == 0) begin
        $display("%0t: unexpected result: next_hop %0d found %0b", $time,
                 rsp_if.next_hop, rsp_if.found);
        mismatches++;
      end else begin
        want = pending_hops.pop_front();
        if (rsp_if.next_hop !== want.next_hop) begin
          $display("%0t: next_hop for %0d->%0d: expected %0d, got %0d", $time,
                   want.start, want.target, want.next_hop, rsp_if.next_hop);
          mismatches++;
        end
        if (rsp_if.found !== want.found) begin
          $display("%0t: found for %0d->%0d: expected %0b, got %0b", $time,
                   want.start, want.target, want.found, rsp_if.found);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.kind         = trnh_pkg::KIND_WRITE;
    req_if.node_a       = '0;
    req_if.node_b       = '0;
    req_if.edge_present = 1'b0;
    rsp_if.ready        = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_trees();
    test_output_holdoff();
    test_no_idle();
    wait_drain();
    $display("Sent %0d items: %0d edge writes, %0d queries", sent_items, n_writes, n_queries);
    $display("Queries reaching the target: %0d, unreachable: %0d", n_found, n_lost);
    if (mismatches == 0 && pending_hops.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding", pending_hops.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
